@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

@@ rtl/rdmc_pkg.sv @@
// Types, constants and drive tables of the drive mode controller.
package rdmc_pkg;

	localparam int IR_W     = 10;
	localparam int TIME_W   = 32;
	localparam int PERIOD_W = 16;
	localparam int SPEED_W  = 8;
	localparam int CMD_W    = 8;
	localparam int ADDR_W   = 4;
	localparam int DATA_W   = 32;

	localparam logic [IR_W-1:0]     IR_THRESHOLD_RST = 10'd50;
	localparam logic [PERIOD_W-1:0] AUTO_PERIOD_RST  = 16'd25;
	localparam logic [PERIOD_W-1:0] AUTO_HOLD_RST    = 16'd500;

	// Register indexes (byte address divided by four).
	localparam logic [1:0] REG_IR_THRESHOLD = 2'd0;
	localparam logic [1:0] REG_AUTO_PERIOD  = 2'd1;
	localparam logic [1:0] REG_AUTO_HOLD    = 2'd2;

	// Command letters.
	localparam logic [CMD_W-1:0] CMD_FORWARD  = 8'h41; // 'A'
	localparam logic [CMD_W-1:0] CMD_BACKWARD = 8'h42; // 'B'
	localparam logic [CMD_W-1:0] CMD_SPIN_C   = 8'h43; // 'C'
	localparam logic [CMD_W-1:0] CMD_SPIN_D   = 8'h44; // 'D'
	localparam logic [CMD_W-1:0] CMD_AUTO     = 8'h45; // 'E'
	localparam logic [CMD_W-1:0] CMD_KEEP     = 8'h5A; // 'Z'
	localparam logic [SPEED_W-1:0] AUTO_KEY   = 8'd255;

	localparam logic [SPEED_W-1:0] SPD_STRAIGHT = 8'd110;
	localparam logic [SPEED_W-1:0] SPD_TURN     = 8'd128;
	localparam logic [SPEED_W-1:0] SPD_FAST     = 8'd150;
	localparam logic [SPEED_W-1:0] SPD_MEDIUM   = 8'd80;
	localparam logic [SPEED_W-1:0] SPD_SLOW     = 8'd50;
	localparam logic [SPEED_W-1:0] SPD_CRAWL    = 8'd20;

	typedef enum logic [2:0] {
		MODE_FALLBACK  = 3'd0,
		MODE_RUNNING   = 3'd1,
		MODE_COLLISION = 3'd2,
		MODE_AUTO      = 3'd3,
		MODE_RECV      = 3'd4,
		MODE_RECV_COLL = 3'd5
	} mode_t;

	typedef enum logic [2:0] {
		APAT_NONE  = 3'd0,
		APAT_LEFT  = 3'd1,
		APAT_RIGHT = 3'd2,
		APAT_MID   = 3'd3,
		APAT_TWO_L = 3'd4,
		APAT_TWO_R = 3'd5,
		APAT_THREE = 3'd6
	} apat_t;

	typedef struct packed {
		logic               wr;
		logic               rev;
		logic [SPEED_W-1:0] speed;
	} motor_cmd_t;

	typedef struct packed {
		motor_cmd_t right;
		motor_cmd_t left;
	} drive_pair_t;

	localparam motor_cmd_t MOTOR_IDLE = '{wr: 1'b0, rev: 1'b0, speed: '0};

	function automatic motor_cmd_t motor(input logic rev, input logic [SPEED_W-1:0] speed);
		motor_cmd_t m;
		m.wr    = 1'b1;
		m.rev   = rev;
		m.speed = speed;
		return m;
	endfunction

	// Fixed turn speeds of the autonomous drive for each obstacle pattern.
	function automatic drive_pair_t auto_drive(input apat_t p);
		drive_pair_t d;
		case (p)
			APAT_NONE: begin
				d.right = motor(1'b0, SPD_STRAIGHT);
				d.left  = motor(1'b0, SPD_STRAIGHT);
			end
			APAT_LEFT: begin
				d.right = motor(1'b1, SPD_TURN);
				d.left  = motor(1'b0, SPD_SLOW);
			end
			APAT_RIGHT: begin
				d.right = motor(1'b0, SPD_SLOW);
				d.left  = motor(1'b1, SPD_TURN);
			end
			APAT_MID: begin
				d.right = motor(1'b1, SPD_FAST);
				d.left  = motor(1'b0, SPD_MEDIUM);
			end
			APAT_TWO_L: begin
				d.right = motor(1'b1, SPD_FAST);
				d.left  = motor(1'b0, SPD_CRAWL);
			end
			APAT_TWO_R: begin
				d.right = motor(1'b0, SPD_CRAWL);
				d.left  = motor(1'b1, SPD_FAST);
			end
			default: begin
				d.right = motor(1'b1, SPD_FAST);
				d.left  = motor(1'b1, SPD_CRAWL);
			end
		endcase
		return d;
	endfunction

endpackage

@@ rtl/rdmc_if.sv @@
// Input and result channel interfaces of the drive mode controller.
interface rdmc_in_if;
	logic                        valid;
	logic                        ready;
	logic                        link_alive;
	logic                        frame_received;
	logic [rdmc_pkg::CMD_W-1:0]   command_code;
	logic [rdmc_pkg::SPEED_W-1:0] value_a;
	logic [rdmc_pkg::SPEED_W-1:0] value_b;
	logic [rdmc_pkg::IR_W-1:0]    ir_left_sample;
	logic [rdmc_pkg::IR_W-1:0]    ir_mid_sample;
	logic [rdmc_pkg::IR_W-1:0]    ir_right_sample;
	logic [rdmc_pkg::TIME_W-1:0]  now_ms;

	modport source (
		output valid, link_alive, frame_received, command_code, value_a, value_b,
		output ir_left_sample, ir_mid_sample, ir_right_sample, now_ms,
		input  ready
	);
	modport sink (
		input  valid, link_alive, frame_received, command_code, value_a, value_b,
		input  ir_left_sample, ir_mid_sample, ir_right_sample, now_ms,
		output ready
	);
endinterface

interface rdmc_out_if;
	logic                        valid;
	logic                        ready;
	logic [2:0]                  mode;
	logic                        right_write;
	logic                        right_reverse;
	logic [rdmc_pkg::SPEED_W-1:0] right_speed;
	logic                        left_write;
	logic                        left_reverse;
	logic [rdmc_pkg::SPEED_W-1:0] left_speed;
	logic                        lamp_on;
	logic [2:0]                  sensor_pattern;

	modport source (
		output valid, mode, right_write, right_reverse, right_speed,
		output left_write, left_reverse, left_speed, lamp_on, sensor_pattern,
		input  ready
	);
	modport sink (
		input  valid, mode, right_write, right_reverse, right_speed,
		input  left_write, left_reverse, left_speed, lamp_on, sensor_pattern,
		output ready
	);
endinterface

@@ rtl/robot_drive_mode_controller.sv @@
// Drive mode controller: one control tick per input beat, one result beat per tick.
//
//  channel  | direction | beat carries
//  ---------+-----------+------------------------------------------------------
//  in_ch    | in        | link status, command letter and bytes, IR samples, time
//  out_ch   | out       | mode, right and left motor commands, lamp, IR pattern
//  APB      | in/out    | ir_threshold, auto_period_ms, auto_hold_ms
//
// A tick passes from input beat to result beat through the input register, then
// the mode logic (two 32-bit time subtractions and compares) into the result register.
// One beat is accepted every cycle while the result side keeps taking beats.
// A stalled result holds in the result register while one more beat waits in the input register.
// arst_n clears the mode state, the valid flags and the configuration registers to their reset values.
module robot_drive_mode_controller (
	input  logic                          clk,
	input  logic                          arst_n,
	rdmc_in_if.sink                       in_ch,
	rdmc_out_if.source                    out_ch,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [rdmc_pkg::ADDR_W-1:0]   paddr,
	input  logic [rdmc_pkg::DATA_W-1:0]   pwdata,
	output logic [rdmc_pkg::DATA_W-1:0]   prdata,
	output logic                          pready
);

	// Configuration registers.
	logic [rdmc_pkg::IR_W-1:0]     ir_threshold_q;
	logic [rdmc_pkg::PERIOD_W-1:0] auto_period_q;
	logic [rdmc_pkg::PERIOD_W-1:0] auto_hold_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ir_threshold_q <= rdmc_pkg::IR_THRESHOLD_RST;
			auto_period_q  <= rdmc_pkg::AUTO_PERIOD_RST;
			auto_hold_q    <= rdmc_pkg::AUTO_HOLD_RST;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[3:2])
				rdmc_pkg::REG_IR_THRESHOLD: ir_threshold_q <= pwdata[rdmc_pkg::IR_W-1:0];
				rdmc_pkg::REG_AUTO_PERIOD:  auto_period_q  <= pwdata[rdmc_pkg::PERIOD_W-1:0];
				rdmc_pkg::REG_AUTO_HOLD:    auto_hold_q    <= pwdata[rdmc_pkg::PERIOD_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			rdmc_pkg::REG_IR_THRESHOLD:
				prdata = {{(rdmc_pkg::DATA_W-rdmc_pkg::IR_W){1'b0}}, ir_threshold_q};
			rdmc_pkg::REG_AUTO_PERIOD:
				prdata = {{(rdmc_pkg::DATA_W-rdmc_pkg::PERIOD_W){1'b0}}, auto_period_q};
			rdmc_pkg::REG_AUTO_HOLD:
				prdata = {{(rdmc_pkg::DATA_W-rdmc_pkg::PERIOD_W){1'b0}}, auto_hold_q};
			default:
				prdata = '0;
		endcase
	end

	// Input register.
	logic                          valid_s1;
	logic                          alive_s1;
	logic                          rx_s1;
	logic [rdmc_pkg::CMD_W-1:0]    cmd_s1;
	logic [rdmc_pkg::SPEED_W-1:0]  va_s1;
	logic [rdmc_pkg::SPEED_W-1:0]  vb_s1;
	logic [rdmc_pkg::IR_W-1:0]     ir_l_s1;
	logic [rdmc_pkg::IR_W-1:0]     ir_m_s1;
	logic [rdmc_pkg::IR_W-1:0]     ir_r_s1;
	logic [rdmc_pkg::TIME_W-1:0]   now_s1;

	logic accept_in;
	logic adv;

	assign accept_in   = in_ch.valid && in_ch.ready;
	assign adv         = valid_s1 && (!out_ch.valid || out_ch.ready);
	assign in_ch.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept_in) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept_in) begin
			alive_s1 <= in_ch.link_alive;
			rx_s1    <= in_ch.frame_received;
			cmd_s1   <= in_ch.command_code;
			va_s1    <= in_ch.value_a;
			vb_s1    <= in_ch.value_b;
			ir_l_s1  <= in_ch.ir_left_sample;
			ir_m_s1  <= in_ch.ir_mid_sample;
			ir_r_s1  <= in_ch.ir_right_sample;
			now_s1   <= in_ch.now_ms;
		end
	end

	// Controller state.
	rdmc_pkg::mode_t             mode_q;
	rdmc_pkg::mode_t             mode_applied_q;
	rdmc_pkg::apat_t             apat_q;
	rdmc_pkg::apat_t             apat_applied_q;
	logic [rdmc_pkg::TIME_W-1:0] refresh_start_q;
	logic [rdmc_pkg::TIME_W-1:0] last_hit_q;
	logic                        lamp_q;

	logic l_hit, m_hit, r_hit, any_hit, auto_cmd;
	logic [2:0] sensor_pat;

	assign l_hit    = ir_l_s1 < ir_threshold_q;
	assign m_hit    = ir_m_s1 < ir_threshold_q;
	assign r_hit    = ir_r_s1 < ir_threshold_q;
	assign any_hit  = l_hit || m_hit || r_hit;
	assign auto_cmd = (cmd_s1 == rdmc_pkg::CMD_AUTO) && (va_s1 == rdmc_pkg::AUTO_KEY)
		&& (vb_s1 == rdmc_pkg::AUTO_KEY);

	// Left and right without middle reports as left only.
	assign sensor_pat = {l_hit, m_hit, r_hit && (m_hit || !l_hit)};

	// Next mode and lamp.
	rdmc_pkg::mode_t mode_d;
	logic            lamp_d;
	logic            coll_stop;

	always_comb begin
		mode_d    = mode_q;
		lamp_d    = lamp_q;
		coll_stop = 1'b0;
		unique case (mode_q)
			rdmc_pkg::MODE_FALLBACK: begin
				if (alive_s1) begin
					mode_d = rdmc_pkg::MODE_RUNNING;
					lamp_d = 1'b1;
				end
			end
			rdmc_pkg::MODE_RUNNING: begin
				if (!alive_s1) begin
					mode_d = rdmc_pkg::MODE_FALLBACK;
					lamp_d = 1'b0;
				end else if (any_hit) begin
					mode_d    = rdmc_pkg::MODE_COLLISION;
					coll_stop = 1'b1;
				end else if (rx_s1) begin
					mode_d = rdmc_pkg::MODE_RECV;
				end else if (auto_cmd) begin
					mode_d = rdmc_pkg::MODE_AUTO;
					lamp_d = 1'b1;
				end
			end
			rdmc_pkg::MODE_COLLISION: begin
				if (!alive_s1) begin
					mode_d = rdmc_pkg::MODE_FALLBACK;
					lamp_d = 1'b0;
				end else if (!any_hit) begin
					mode_d = rdmc_pkg::MODE_RUNNING;
				end else if (rx_s1) begin
					mode_d = rdmc_pkg::MODE_RECV_COLL;
				end
			end
			rdmc_pkg::MODE_AUTO: begin
				if (!alive_s1) begin
					mode_d = rdmc_pkg::MODE_FALLBACK;
					lamp_d = 1'b0;
				end else if (!auto_cmd && cmd_s1 != rdmc_pkg::CMD_KEEP) begin
					mode_d = rdmc_pkg::MODE_RUNNING;
				end
			end
			rdmc_pkg::MODE_RECV_COLL: mode_d = rdmc_pkg::MODE_COLLISION;
			rdmc_pkg::MODE_RECV:      mode_d = rdmc_pkg::MODE_RUNNING;
			default: ;
		endcase
	end

	// Autonomous refresh.
	logic                        mode_changed;
	logic                        entering_auto;
	logic [rdmc_pkg::TIME_W-1:0] refresh_base;
	logic [rdmc_pkg::TIME_W-1:0] since_refresh;
	logic [rdmc_pkg::TIME_W-1:0] since_hit;
	logic                        do_refresh;
	rdmc_pkg::apat_t             applied_base;
	rdmc_pkg::apat_t             apat_d;
	logic                        pat_changed;

	assign mode_changed  = mode_d != mode_applied_q;
	assign entering_auto = mode_changed && (mode_d == rdmc_pkg::MODE_AUTO);
	assign refresh_base  = entering_auto ? now_s1 : refresh_start_q;
	assign since_refresh = now_s1 - refresh_base;
	assign since_hit     = now_s1 - last_hit_q;
	assign do_refresh    = (mode_d == rdmc_pkg::MODE_AUTO) && (since_refresh >=
		{{(rdmc_pkg::TIME_W-rdmc_pkg::PERIOD_W){1'b0}}, auto_period_q});

	// Entering autonomous from running takes the applied pattern as all three sensors hit.
	assign applied_base = (mode_q == rdmc_pkg::MODE_RUNNING && mode_d == rdmc_pkg::MODE_AUTO)
		? rdmc_pkg::APAT_THREE : apat_applied_q;

	always_comb begin
		apat_d = apat_q;
		if (do_refresh) begin
			if (l_hit && m_hit && r_hit)  apat_d = rdmc_pkg::APAT_THREE;
			else if (l_hit && m_hit)      apat_d = rdmc_pkg::APAT_TWO_L;
			else if (m_hit && r_hit)      apat_d = rdmc_pkg::APAT_TWO_R;
			else if (m_hit)               apat_d = rdmc_pkg::APAT_MID;
			else if (l_hit)               apat_d = rdmc_pkg::APAT_LEFT;
			else if (r_hit)               apat_d = rdmc_pkg::APAT_RIGHT;
			else if (since_hit > {{(rdmc_pkg::TIME_W-rdmc_pkg::PERIOD_W){1'b0}}, auto_hold_q})
				apat_d = rdmc_pkg::APAT_NONE;
		end
	end

	assign pat_changed = do_refresh && (apat_d != applied_base);

	// Motor commands; a later write in the tick replaces an earlier one.
	rdmc_pkg::motor_cmd_t right_d;
	rdmc_pkg::motor_cmd_t left_d;
	rdmc_pkg::drive_pair_t auto_cmds;

	assign auto_cmds = rdmc_pkg::auto_drive(apat_d);

	always_comb begin
		right_d = rdmc_pkg::MOTOR_IDLE;
		left_d  = rdmc_pkg::MOTOR_IDLE;
		if (coll_stop) begin
			right_d = rdmc_pkg::motor(1'b0, '0);
			left_d  = rdmc_pkg::motor(1'b0, '0);
		end
		if (mode_changed) begin
			unique case (mode_d)
				rdmc_pkg::MODE_FALLBACK: begin
					right_d = rdmc_pkg::motor(1'b0, '0);
					left_d  = rdmc_pkg::motor(1'b0, '0);
				end
				rdmc_pkg::MODE_RUNNING: begin
					case (cmd_s1)
						rdmc_pkg::CMD_FORWARD: begin
							right_d = rdmc_pkg::motor(1'b0, va_s1);
							left_d  = rdmc_pkg::motor(1'b0, vb_s1);
						end
						rdmc_pkg::CMD_BACKWARD: begin
							right_d = rdmc_pkg::motor(1'b1, va_s1);
							left_d  = rdmc_pkg::motor(1'b1, vb_s1);
						end
						rdmc_pkg::CMD_SPIN_C: begin
							right_d = rdmc_pkg::motor(1'b0, va_s1);
							left_d  = rdmc_pkg::motor(1'b1, vb_s1);
						end
						rdmc_pkg::CMD_SPIN_D: begin
							right_d = rdmc_pkg::motor(1'b1, va_s1);
							left_d  = rdmc_pkg::motor(1'b0, vb_s1);
						end
						default: ;
					endcase
				end
				rdmc_pkg::MODE_COLLISION: begin
					// Forward drive is refused while in collision.
					case (cmd_s1)
						rdmc_pkg::CMD_BACKWARD: begin
							right_d = rdmc_pkg::motor(1'b1, va_s1);
							left_d  = rdmc_pkg::motor(1'b1, vb_s1);
						end
						rdmc_pkg::CMD_SPIN_C: left_d  = rdmc_pkg::motor(1'b1, vb_s1);
						rdmc_pkg::CMD_SPIN_D: right_d = rdmc_pkg::motor(1'b1, va_s1);
						default: ;
					endcase
				end
				default: ;
			endcase
		end
		if (pat_changed) begin
			right_d = auto_cmds.right;
			left_d  = auto_cmds.left;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q          <= rdmc_pkg::MODE_FALLBACK;
			mode_applied_q  <= rdmc_pkg::MODE_RUNNING;
			apat_q          <= rdmc_pkg::APAT_NONE;
			apat_applied_q  <= rdmc_pkg::APAT_THREE;
			refresh_start_q <= '0;
			last_hit_q      <= '0;
			lamp_q          <= 1'b0;
		end else if (adv) begin
			mode_q          <= mode_d;
			mode_applied_q  <= mode_d;
			apat_q          <= apat_d;
			apat_applied_q  <= pat_changed ? apat_d : applied_base;
			refresh_start_q <= do_refresh ? now_s1 : refresh_base;
			if (pat_changed && apat_d != rdmc_pkg::APAT_NONE) begin
				last_hit_q <= now_s1;
			end
			lamp_q          <= lamp_d;
		end
	end

	// Result register.
	logic                         out_valid_s2;
	rdmc_pkg::mode_t              mode_s2;
	rdmc_pkg::motor_cmd_t         right_s2;
	rdmc_pkg::motor_cmd_t         left_s2;
	logic                         lamp_s2;
	logic [2:0]                   pat_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (adv) begin
			out_valid_s2 <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mode_s2  <= mode_d;
			right_s2 <= right_d;
			left_s2  <= left_d;
			lamp_s2  <= lamp_d;
			pat_s2   <= sensor_pat;
		end
	end

	assign out_ch.valid          = out_valid_s2;
	assign out_ch.mode           = mode_s2;
	assign out_ch.right_write    = right_s2.wr;
	assign out_ch.right_reverse  = right_s2.rev;
	assign out_ch.right_speed    = right_s2.speed;
	assign out_ch.left_write     = left_s2.wr;
	assign out_ch.left_reverse   = left_s2.rev;
	assign out_ch.left_speed     = left_s2.speed;
	assign out_ch.lamp_on        = lamp_s2;
	assign out_ch.sensor_pattern = pat_s2;

endmodule

@@ rtl/rdmc_checker.sv @@
// Port-level checker of the drive mode controller and its bind statement.
`include "assert_macros.svh"

module rdmc_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [2:0]                   mode,
	input logic                         right_write,
	input logic                         right_reverse,
	input logic [rdmc_pkg::SPEED_W-1:0] right_speed,
	input logic                         left_write,
	input logic                         left_reverse,
	input logic [rdmc_pkg::SPEED_W-1:0] left_speed,
	input logic                         lamp_on
);

	// A motor that gets no command this tick reports zero direction and speed.
	`ASSERT_IMPL(a_right_idle, clk, arst_n, out_valid && !right_write,
		!right_reverse && right_speed == '0)
	`ASSERT_IMPL(a_left_idle, clk, arst_n, out_valid && !left_write,
		!left_reverse && left_speed == '0)

	// Every fallback result has the lamp switched off and both motor speeds at zero.
	`ASSERT_IMPL(a_fallback_dark, clk, arst_n, out_valid && mode == rdmc_pkg::MODE_FALLBACK,
		!lamp_on && right_speed == '0 && left_speed == '0)

	// A result beat that is not taken stays offered.
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)

endmodule

bind robot_drive_mode_controller rdmc_checker u_rdmc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_ch.valid),
	.out_ready     (out_ch.ready),
	.mode          (out_ch.mode),
	.right_write   (out_ch.right_write),
	.right_reverse (out_ch.right_reverse),
	.right_speed   (out_ch.right_speed),
	.left_write    (out_ch.left_write),
	.left_reverse  (out_ch.left_reverse),
	.left_speed    (out_ch.left_speed),
	.lamp_on       (out_ch.lamp_on)
);

@@ tb/robot_drive_mode_controller_tb.sv @@
// Self-checking testbench of the robot drive mode controller with a scoreboard class.
module robot_drive_mode_controller_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import rdmc_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASE_ITEMS = 255;
	localparam int MAX_SHOWN   = 10;

	// Kinds of random stretches of control ticks.
	localparam int EP_SEEK   = 0;
	localparam int EP_MANUAL = 1;
	localparam int EP_NOISE  = 2;
	localparam int EP_LINK   = 3;

	typedef struct packed {
		logic               alive;
		logic               frame;
		logic [CMD_W-1:0]   cmd;
		logic [SPEED_W-1:0] val_a;
		logic [SPEED_W-1:0] val_b;
		logic [IR_W-1:0]    ir_l;
		logic [IR_W-1:0]    ir_m;
		logic [IR_W-1:0]    ir_r;
		logic [TIME_W-1:0]  now;
	} tick_t;

	typedef struct packed {
		logic [2:0] mode;
		motor_cmd_t right;
		motor_cmd_t left;
		logic       lamp;
		logic [2:0] pattern;
	} report_t;

	class drive_mode_scoreboard;
		logic [IR_W-1:0]     thresh;
		logic [PERIOD_W-1:0] period_ms;
		logic [PERIOD_W-1:0] hold_ms;
		mode_t               cur_mode;
		mode_t               applied_mode;
		apat_t               avoid;
		apat_t               applied_avoid;
		logic [TIME_W-1:0]   refresh_mark;
		logic [TIME_W-1:0]   hit_mark;
		logic                lamp_lit;
		report_t             expected_reports[$];
		int                  errors;

		function new();
			thresh        = IR_THRESHOLD_RST;
			period_ms     = AUTO_PERIOD_RST;
			hold_ms       = AUTO_HOLD_RST;
			cur_mode      = MODE_FALLBACK;
			applied_mode  = MODE_RUNNING;
			avoid         = APAT_NONE;
			applied_avoid = APAT_THREE;
			refresh_mark  = '0;
			hit_mark      = '0;
			lamp_lit      = 1'b0;
			errors        = 0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [DATA_W-1:0] val);
			case (idx)
				REG_IR_THRESHOLD: thresh = val[IR_W-1:0];
				REG_AUTO_PERIOD:  period_ms = val[PERIOD_W-1:0];
				REG_AUTO_HOLD:    hold_ms = val[PERIOD_W-1:0];
				default: ;
			endcase
		endfunction

		function motor_cmd_t motor_word(logic rev, logic [SPEED_W-1:0] spd);
			motor_cmd_t w;
			w.wr    = 1'b1;
			w.rev   = rev;
			w.speed = spd;
			return w;
		endfunction

		function int outstanding();
			return expected_reports.size();
		endfunction

		function void note_tick(tick_t t);
			report_t           e;
			logic              l, m, r, any_hit, auto_key;
			logic [TIME_W-1:0] since_refresh, since_hit;
			e        = '0;
			l        = t.ir_l < thresh;
			m        = t.ir_m < thresh;
			r        = t.ir_r < thresh;
			any_hit  = l | m | r;
			auto_key = (t.cmd == CMD_AUTO) && (t.val_a == AUTO_KEY) && (t.val_b == AUTO_KEY);
			// Left and right without the middle sensor report as left only.
			e.pattern = m ? {l, m, r} : (l ? 3'b100 : {2'b00, r});

			case (cur_mode)
				MODE_FALLBACK: begin
					if (t.alive) begin
						cur_mode = MODE_RUNNING;
						lamp_lit = 1'b1;
					end
				end
				MODE_RUNNING: begin
					if (!t.alive) begin
						cur_mode = MODE_FALLBACK;
						lamp_lit = 1'b0;
					end else if (any_hit) begin
						cur_mode = MODE_COLLISION;
						e.right  = motor_word(1'b0, '0);
						e.left   = motor_word(1'b0, '0);
					end else if (t.frame) begin
						cur_mode = MODE_RECV;
					end else if (auto_key) begin
						cur_mode      = MODE_AUTO;
						applied_avoid = APAT_THREE;
						lamp_lit      = 1'b1;
					end
				end
				MODE_COLLISION: begin
					if (!t.alive) begin
						cur_mode = MODE_FALLBACK;
						lamp_lit = 1'b0;
					end else if (!any_hit) begin
						cur_mode = MODE_RUNNING;
					end else if (t.frame) begin
						cur_mode = MODE_RECV_COLL;
					end
				end
				MODE_AUTO: begin
					if (!t.alive) begin
						cur_mode = MODE_FALLBACK;
						lamp_lit = 1'b0;
					end else if (!auto_key && t.cmd != CMD_KEEP) begin
						cur_mode = MODE_RUNNING;
					end
				end
				MODE_RECV_COLL: cur_mode = MODE_COLLISION;
				MODE_RECV:      cur_mode = MODE_RUNNING;
				default: ;
			endcase

			// Commands for the new mode go out only on the tick that changes the mode.
			if (cur_mode != applied_mode) begin
				applied_mode = cur_mode;
				case (cur_mode)
					MODE_FALLBACK: begin
						e.right = motor_word(1'b0, '0);
						e.left  = motor_word(1'b0, '0);
					end
					MODE_RUNNING: begin
						case (t.cmd)
							CMD_FORWARD: begin
								e.right = motor_word(1'b0, t.val_a);
								e.left  = motor_word(1'b0, t.val_b);
							end
							CMD_BACKWARD: begin
								e.right = motor_word(1'b1, t.val_a);
								e.left  = motor_word(1'b1, t.val_b);
							end
							CMD_SPIN_C: begin
								e.right = motor_word(1'b0, t.val_a);
								e.left  = motor_word(1'b1, t.val_b);
							end
							CMD_SPIN_D: begin
								e.right = motor_word(1'b1, t.val_a);
								e.left  = motor_word(1'b0, t.val_b);
							end
							default: ;
						endcase
					end
					MODE_COLLISION: begin
						// Forward is refused here; only backing moves are issued.
						case (t.cmd)
							CMD_BACKWARD: begin
								e.right = motor_word(1'b1, t.val_a);
								e.left  = motor_word(1'b1, t.val_b);
							end
							CMD_SPIN_C: e.left = motor_word(1'b1, t.val_b);
							CMD_SPIN_D: e.right = motor_word(1'b1, t.val_a);
							default: ;
						endcase
					end
					MODE_AUTO: refresh_mark = t.now;
					default: ;
				endcase
			end

			since_refresh = t.now - refresh_mark;
			if (cur_mode == MODE_AUTO && since_refresh >= {16'd0, period_ms}) begin
				refresh_mark = t.now;
				since_hit    = t.now - hit_mark;
				if (l && m && r)
					avoid = APAT_THREE;
				else if (l && m)
					avoid = APAT_TWO_L;
				else if (m && r)
					avoid = APAT_TWO_R;
				else if (m)
					avoid = APAT_MID;
				else if (l)
					avoid = APAT_LEFT;
				else if (r)
					avoid = APAT_RIGHT;
				else if (since_hit > {16'd0, hold_ms})
					avoid = APAT_NONE;

				if (avoid != applied_avoid) begin
					applied_avoid = avoid;
					if (avoid != APAT_NONE)
						hit_mark = t.now;
					case (avoid)
						APAT_NONE: begin
							e.right = motor_word(1'b0, SPD_STRAIGHT);
							e.left  = motor_word(1'b0, SPD_STRAIGHT);
						end
						APAT_LEFT: begin
							e.right = motor_word(1'b1, SPD_TURN);
							e.left  = motor_word(1'b0, SPD_SLOW);
						end
						APAT_RIGHT: begin
							e.right = motor_word(1'b0, SPD_SLOW);
							e.left  = motor_word(1'b1, SPD_TURN);
						end
						APAT_MID: begin
							e.right = motor_word(1'b1, SPD_FAST);
							e.left  = motor_word(1'b0, SPD_MEDIUM);
						end
						APAT_TWO_L: begin
							e.right = motor_word(1'b1, SPD_FAST);
							e.left  = motor_word(1'b0, SPD_CRAWL);
						end
						APAT_TWO_R: begin
							e.right = motor_word(1'b0, SPD_CRAWL);
							e.left  = motor_word(1'b1, SPD_FAST);
						end
						default: begin
							e.right = motor_word(1'b1, SPD_FAST);
							e.left  = motor_word(1'b1, SPD_CRAWL);
						end
					endcase
				end
			end

			e.mode = cur_mode;
			e.lamp = lamp_lit;
			expected_reports.push_back(e);
		endfunction

		function string show(report_t x);
			return $sformatf("mode=%0d right=%b/%b/%0d left=%b/%b/%0d lamp=%b pattern=%b",
				x.mode, x.right.wr, x.right.rev, x.right.speed,
				x.left.wr, x.left.rev, x.left.speed, x.lamp, x.pattern);
		endfunction

		function void check_report(report_t got);
			report_t e;
			logic    bad;
			if (expected_reports.size() == 0) begin
				errors++;
				if (errors <= MAX_SHOWN)
					$display("unexpected result beat: %s", show(got));
				return;
			end
			e   = expected_reports.pop_front();
			bad = (got.mode !== e.mode) || (got.right.wr !== e.right.wr)
				|| (got.right.rev !== e.right.rev) || (got.right.speed !== e.right.speed)
				|| (got.left.wr !== e.left.wr) || (got.left.rev !== e.left.rev)
				|| (got.left.speed !== e.left.speed) || (got.lamp !== e.lamp)
				|| (got.pattern !== e.pattern);
			if (bad) begin
				errors++;
				if (errors <= MAX_SHOWN)
					$display("result mismatch at %0t: expected %s, got %s", $realtime,
						show(e), show(got));
			end
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [ADDR_W-1:0]   paddr;
	logic [DATA_W-1:0]   pwdata;
	logic [DATA_W-1:0]   prdata;
	logic                pready;

	rdmc_in_if  in_ch();
	rdmc_out_if out_ch();

	robot_drive_mode_controller dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.out_ch  (out_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	drive_mode_scoreboard sb;
	int                   send_idle_pct;
	int                   recv_idle_pct;
	int                   cycles;

	// State of the random tick generator.
	int                   ep_left;
	int                   ep_kind;
	int                   ep_obs;
	int                   ep_step;
	logic [TIME_W-1:0]    now_cursor;

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	function automatic tick_t mk_tick(logic alive, logic frame, logic [7:0] cmd,
			logic [7:0] va, logic [7:0] vb, logic [9:0] il, logic [9:0] im,
			logic [9:0] ir, logic [31:0] now);
		tick_t t;
		t.alive = alive;
		t.frame = frame;
		t.cmd   = cmd;
		t.val_a = va;
		t.val_b = vb;
		t.ir_l  = il;
		t.ir_m  = im;
		t.ir_r  = ir;
		t.now   = now;
		return t;
	endfunction

	function automatic logic [IR_W-1:0] ir_sample();
		if (ep_kind == EP_NOISE)
			return IR_W'($urandom_range(0, 1023));
		if (sb.thresh != 0 && $urandom_range(0, 99) < ep_obs)
			return IR_W'($urandom_range(0, sb.thresh - 1));
		return IR_W'($urandom_range(sb.thresh, 1023));
	endfunction

	function automatic tick_t random_tick();
		tick_t t;
		int    roll;
		if (ep_left == 0) begin
			ep_left = $urandom_range(10, 40);
			roll    = $urandom_range(0, 9);
			ep_kind = (roll < 6) ? EP_SEEK : (roll < 8) ? EP_MANUAL :
				(roll < 9) ? EP_NOISE : EP_LINK;
			case ($urandom_range(0, 4))
				0: ep_obs = 0;
				1: ep_obs = 5;
				2: ep_obs = 20;
				3: ep_obs = 50;
				default: ep_obs = 90;
			endcase
			case ($urandom_range(0, 3))
				0: ep_step = 2;
				1: ep_step = 30;
				2: ep_step = 300;
				default: ep_step = 3000;
			endcase
			// Now and then jump the clock, often to just before the wrap.
			case ($urandom_range(0, 7))
				0: now_cursor = $urandom;
				1: now_cursor = 32'hFFFF_FF00 + $urandom_range(0, 255);
				default: ;
			endcase
		end
		ep_left--;
		now_cursor += $urandom_range(0, ep_step);
		t.now  = now_cursor;
		t.ir_l = ir_sample();
		t.ir_m = ir_sample();
		t.ir_r = ir_sample();
		t.val_a = SPEED_W'($urandom_range(0, 255));
		t.val_b = SPEED_W'($urandom_range(0, 255));
		t.alive = (ep_kind == EP_LINK) ? ($urandom_range(0, 99) < 70) :
			($urandom_range(0, 99) < 98);
		case (ep_kind)
			EP_SEEK:   t.frame = $urandom_range(0, 99) < 3;
			EP_MANUAL: t.frame = $urandom_range(0, 99) < 20;
			EP_NOISE:  t.frame = $urandom_range(0, 99) < 50;
			default:   t.frame = $urandom_range(0, 99) < 15;
		endcase
		roll = $urandom_range(0, 99);
		if (ep_kind == EP_SEEK) begin
			if (roll < 80) begin
				t.cmd   = CMD_AUTO;
				t.val_a = AUTO_KEY;
				t.val_b = AUTO_KEY;
			end else if (roll < 92) begin
				t.cmd = CMD_KEEP;
			end else if (roll < 96) begin
				t.cmd = CMD_AUTO;
			end else begin
				t.cmd = CMD_FORWARD + CMD_W'($urandom_range(0, 3));
			end
		end else if (ep_kind == EP_MANUAL) begin
			if (roll < 70)
				t.cmd = CMD_FORWARD + CMD_W'($urandom_range(0, 3));
			else if (roll < 85)
				t.cmd = CMD_KEEP;
			else
				t.cmd = CMD_W'($urandom_range(0, 255));
		end else begin
			t.cmd = CMD_W'($urandom_range(0, 255));
		end
		return t;
	endfunction

	task automatic send_tick(input tick_t t);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid           <= 1'b1;
		in_ch.link_alive      <= t.alive;
		in_ch.frame_received  <= t.frame;
		in_ch.command_code    <= t.cmd;
		in_ch.value_a         <= t.val_a;
		in_ch.value_b         <= t.val_b;
		in_ch.ir_left_sample  <= t.ir_l;
		in_ch.ir_mid_sample   <= t.ir_m;
		in_ch.ir_right_sample <= t.ir_r;
		in_ch.now_ms          <= t.now;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		sb.note_tick(t);
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		while (sb.outstanding() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [DATA_W-1:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		sb.set_reg(idx, val);
		// Waiting for a clock edge with psel low keeps back-to-back writes apart.
		@(posedge clk);
	endtask

	// Result side: take a beat when valid meets ready, stall at random.
	initial begin
		report_t got;
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_ch.valid && out_ch.ready) begin
				got.mode        = out_ch.mode;
				got.right.wr    = out_ch.right_write;
				got.right.rev   = out_ch.right_reverse;
				got.right.speed = out_ch.right_speed;
				got.left.wr     = out_ch.left_write;
				got.left.rev    = out_ch.left_reverse;
				got.left.speed  = out_ch.left_speed;
				got.lamp        = out_ch.lamp_on;
				got.pattern     = out_ch.sensor_pattern;
				sb.check_report(got);
			end
			out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("robot_drive_mode_controller_tb: FAIL");
		$finish;
	end

	initial begin
		logic [DATA_W-1:0] cfg_thr, cfg_per, cfg_hold;
		int                pause_at;
		sb            = new();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		ep_left       = 0;
		ep_kind       = EP_SEEK;
		ep_obs        = 0;
		ep_step       = 1;
		now_cursor    = '0;
		arst_n                <= 1'b0;
		psel                  <= 1'b0;
		penable               <= 1'b0;
		pwrite                <= 1'b0;
		paddr                 <= '0;
		pwdata                <= '0;
		in_ch.valid           <= 1'b0;
		in_ch.link_alive      <= 1'b0;
		in_ch.frame_received  <= 1'b0;
		in_ch.command_code    <= '0;
		in_ch.value_a         <= '0;
		in_ch.value_b         <= '0;
		in_ch.ir_left_sample  <= '0;
		in_ch.ir_mid_sample   <= '0;
		in_ch.ir_right_sample <= '0;
		in_ch.now_ms          <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed walk through every mode and most drive cases, reset settings.
		send_tick(mk_tick(0, 0, 8'h00, 8'h00, 8'h00, 1023, 1023, 1023, 32'd0));
		send_tick(mk_tick(1, 0, CMD_FORWARD, 8'hFF, 8'h00, 1023, 1023, 1023, 32'd5));
		send_tick(mk_tick(1, 1, CMD_BACKWARD, 8'h00, 8'hFF, 1023, 1023, 1023, 32'd10));
		send_tick(mk_tick(1, 0, CMD_BACKWARD, 8'h00, 8'hFF, 1023, 1023, 1023, 32'd15));
		// Left and right hit without the middle; forward is refused in collision.
		send_tick(mk_tick(1, 0, CMD_FORWARD, 8'd200, 8'd200, 0, 1023, 0, 32'd20));
		send_tick(mk_tick(1, 1, CMD_SPIN_C, 8'd1, 8'd2, 49, 49, 49, 32'd25));
		send_tick(mk_tick(1, 0, CMD_SPIN_C, 8'd17, 8'd34, 49, 1023, 1023, 32'd30));
		send_tick(mk_tick(1, 0, 8'hFF, 8'd1, 8'd2, 1023, 1023, 1023, 32'd35));
		send_tick(mk_tick(1, 0, CMD_SPIN_D, 8'd9, 8'd8, 50, 0, 1023, 32'd40));
		send_tick(mk_tick(1, 0, CMD_SPIN_D, 8'd9, 8'd8, 1023, 1023, 1023, 32'd45));
		send_tick(mk_tick(1, 0, CMD_AUTO, AUTO_KEY, AUTO_KEY, 1023, 1023, 1023, 32'd1000));
		send_tick(mk_tick(1, 0, CMD_KEEP, 8'd3, 8'd4, 10, 1023, 1023, 32'd1030));
		send_tick(mk_tick(1, 0, CMD_AUTO, AUTO_KEY, AUTO_KEY, 10, 10, 1023, 32'd1040));
		// Clear view before the hold time is over keeps the turn.
		send_tick(mk_tick(1, 0, CMD_AUTO, AUTO_KEY, AUTO_KEY, 1023, 1023, 1023, 32'd1060));
		send_tick(mk_tick(1, 0, CMD_AUTO, AUTO_KEY, AUTO_KEY, 1023, 1023, 1023, 32'd1600));
		send_tick(mk_tick(1, 0, CMD_KEEP, 8'd0, 8'd0, 1023, 0, 0, 32'hFFFF_FFF0));
		// Elapsed time across the wrap of the millisecond counter.
		send_tick(mk_tick(1, 0, CMD_AUTO, AUTO_KEY, AUTO_KEY, 0, 0, 1023, 32'h0000_0010));
		send_tick(mk_tick(1, 0, CMD_AUTO, AUTO_KEY, AUTO_KEY, 0, 0, 0, 32'h0000_0040));
		send_tick(mk_tick(1, 0, CMD_AUTO, AUTO_KEY, AUTO_KEY, 1023, 0, 1023, 32'h0000_0060));
		send_tick(mk_tick(1, 0, CMD_AUTO, AUTO_KEY, AUTO_KEY, 1023, 1023, 0, 32'h0000_0080));
		send_tick(mk_tick(1, 0, CMD_AUTO, 8'd254, AUTO_KEY, 1023, 1023, 1023, 32'hFFFF_FFFF));
		send_tick(mk_tick(1, 0, CMD_AUTO, AUTO_KEY, AUTO_KEY, 1023, 1023, 1023, 32'd100));
		send_tick(mk_tick(0, 1, CMD_KEEP, 8'hFF, 8'hFF, 0, 0, 0, 32'd200));
		send_tick(mk_tick(1, 0, CMD_SPIN_C, 8'd5, 8'd6, 1023, 1023, 1023, 32'd300));
		send_tick(mk_tick(1, 0, CMD_SPIN_C, 8'd5, 8'd6, 1023, 20, 1023, 32'd310));
		send_tick(mk_tick(0, 0, CMD_SPIN_C, 8'd5, 8'd6, 1023, 20, 1023, 32'd320));

		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin
					cfg_thr  = 50;
					cfg_per  = 25;
					cfg_hold = 500;
				end
				1: begin
					cfg_thr  = 1023;
					cfg_per  = 0;
					cfg_hold = 0;
				end
				2: begin
					cfg_thr  = 0;
					cfg_per  = 65535;
					cfg_hold = 65535;
				end
				3: begin
					cfg_thr  = $urandom_range(20, 1000);
					cfg_per  = $urandom_range(0, 60);
					cfg_hold = $urandom_range(0, 400);
				end
				4: begin
					cfg_thr  = 512;
					cfg_per  = 1;
					cfg_hold = 65535;
				end
				default: begin
					cfg_thr  = $urandom_range(0, 1023);
					cfg_per  = $urandom_range(0, 100);
					cfg_hold = $urandom_range(0, 1000);
				end
			endcase
			send_idle_pct = (ph < 2) ? 16 : (ph < 4) ? 51 : 0;
			recv_idle_pct = (ph < 2) ? 51 : (ph < 4) ? 16 : 0;
			drain();
			write_reg(REG_IR_THRESHOLD, cfg_thr);
			write_reg(REG_AUTO_PERIOD, cfg_per);
			write_reg(REG_AUTO_HOLD, cfg_hold);
			pause_at = $urandom_range(20, PHASE_ITEMS - 20);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				// Mid-phase, hold the input side until every result is back.
				if (i == pause_at)
					drain();
				send_tick(random_tick());
			end
		end

		drain();
		repeat (8) @(posedge clk);
		if (sb.errors == 0 && sb.outstanding() == 0)
			$display("robot_drive_mode_controller_tb: PASS");
		else
			$display("robot_drive_mode_controller_tb: FAIL");
		$finish;
	end

endmodule
